/* hw/rtl/sdat_pkg.sv */
// ----------------------------------------------------------------------------
// sdat_pkg
// Shared types and constants for the dual-channel SPI ADC thermostat.
// ----------------------------------------------------------------------------
package sdat_pkg;

  localparam int unsigned WordW  = 17;
  localparam int unsigned CountW = 5;

  localparam logic [15:0]       CMD_CH1  = 16'hd000;
  localparam logic [15:0]       CMD_CH0  = 16'hf000;
  localparam logic [CountW-1:0] NUM_BITS = 5'd16;
  localparam logic [CountW-1:0] TOP_BIT  = 5'd14;

  localparam logic CFG_NOZZLE_THRESHOLD = 1'b0;
  localparam logic CFG_BED_THRESHOLD    = 1'b1;

  typedef enum logic [2:0] {
    PH_CS_HIGH = 3'd0,
    PH_CLK_LOW = 3'd1,
    PH_CS_LOW  = 3'd2,
    PH_BIT_CLK = 3'd3,
    PH_BIT_RW  = 3'd4,
    PH_LAST    = 3'd5
  } phase_t;

  typedef struct packed {
    logic cs;
    logic clk;
    logic mosi;
    logic noz;
    logic bed;
  } pins_t;

  typedef struct packed {
    phase_t            phase;
    logic [WordW-1:0]  shift_word;
    logic [CountW-1:0] bit_count;
    logic              channel_sel;
    logic [WordW-1:0]  nozzle_reading;
    logic [WordW-1:0]  bed_reading;
    pins_t             pins;
  } sdat_state_t;

endpackage

/* hw/rtl/sdat_step.sv */
// ----------------------------------------------------------------------------
// sdat_step
// Next-state logic for one tick of the SPI master and heater control.
// ----------------------------------------------------------------------------
module sdat_step
  import sdat_pkg::*;
(
  input  sdat_state_t      cur,
  input  logic             miso_bit,
  input  logic [WordW-1:0] nozzle_threshold,
  input  logic [WordW-1:0] bed_threshold,
  output sdat_state_t      nxt,
  output logic             updated
);

  logic [15:0]       cmd;
  logic [3:0]        cmd_pos;
  logic [CountW-1:0] count_inc;
  logic [WordW-1:0]  shifted;

  assign cmd       = cur.channel_sel ? CMD_CH1 : CMD_CH0;
  assign cmd_pos   = 4'(TOP_BIT - cur.bit_count);
  assign count_inc = cur.bit_count + 5'd1;
  assign shifted   = {cur.shift_word[WordW-2:0], miso_bit};

  always_comb begin
    nxt     = cur;
    updated = 1'b0;
    case (cur.phase)
      PH_CLK_LOW: begin
        nxt.pins.clk = 1'b0;
        nxt.phase    = PH_CS_LOW;
      end
      PH_CS_LOW: begin
        nxt.pins.cs   = 1'b0;
        nxt.pins.mosi = 1'b1;
        nxt.phase     = PH_BIT_CLK;
      end
      PH_BIT_CLK: begin
        nxt.pins.clk = 1'b1;
        nxt.phase    = PH_BIT_RW;
      end
      PH_BIT_RW: begin
        nxt.shift_word = shifted;
        nxt.pins.clk   = 1'b0;
        nxt.pins.mosi  = (cur.bit_count <= TOP_BIT) ? cmd[cmd_pos] : 1'b0;
        nxt.bit_count  = count_inc;
        nxt.phase      = (count_inc < NUM_BITS) ? PH_BIT_CLK : PH_LAST;
      end
      PH_LAST: begin
        nxt.shift_word  = shifted;
        nxt.pins.cs     = 1'b1;
        nxt.channel_sel = ~cur.channel_sel;
        nxt.phase       = PH_CS_HIGH;
        updated         = cur.channel_sel;
        if (cur.channel_sel) begin
          nxt.nozzle_reading = shifted;
          nxt.pins.noz       = shifted < nozzle_threshold;
          nxt.pins.bed       = cur.bed_reading < bed_threshold;
        end else begin
          nxt.bed_reading = shifted;
        end
      end
      default: begin
        nxt.pins.cs    = 1'b1;
        nxt.shift_word = '0;
        nxt.bit_count  = '0;
        nxt.phase      = PH_CLK_LOW;
      end
    endcase
  end

endmodule

/* hw/rtl/spi_dual_adc_thermostat.sv */
// ----------------------------------------------------------------------------
// spi_dual_adc_thermostat
// Bit-banged SPI master for a two-channel ADC with on/off heater control.
// ----------------------------------------------------------------------------
// Each accepted input beat is one tick: it carries the sampled MISO level and
// advances the SPI sequence by one phase, and yields exactly one output beat
// with the pin levels, heater drives and latest readings. A beat is accepted
// every cycle while the output side keeps taking results; outputs are registered
// and appear in the cycle after acceptance. A full conversion spans 36 ticks, and
// heaters are re-evaluated when the channel 1 (nozzle) conversion finishes.
// Thresholds are in ADC counts and should be written while no beat is pending.
module spi_dual_adc_thermostat
  import sdat_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic             cfg_index,
  input  logic [WordW-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_miso_bit,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_chip_select,
  output logic             out_serial_clock,
  output logic             out_mosi_bit,
  output logic             out_nozzle_heater,
  output logic             out_bed_heater,
  output logic             out_readings_updated,
  output logic [WordW-1:0] out_nozzle_counts,
  output logic [WordW-1:0] out_bed_counts
);

  sdat_state_t      state_r, state_nxt;
  logic [WordW-1:0] nozzle_thr_r, bed_thr_r;
  logic             out_valid_r, updated_r, updated_nxt;
  logic             accept;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  sdat_step u_step (
    .cur              (state_r),
    .miso_bit         (in_miso_bit),
    .nozzle_threshold (nozzle_thr_r),
    .bed_threshold    (bed_thr_r),
    .nxt              (state_nxt),
    .updated          (updated_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nozzle_thr_r <= '0;
      bed_thr_r    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_NOZZLE_THRESHOLD: nozzle_thr_r <= cfg_wdata;
        CFG_BED_THRESHOLD:    bed_thr_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '{phase: PH_CS_HIGH, default: '0};
      out_valid_r <= 1'b0;
      updated_r   <= 1'b0;
    end else begin
      if (accept) begin
        state_r     <= state_nxt;
        updated_r   <= updated_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_chip_select      = state_r.pins.cs;
  assign out_serial_clock     = state_r.pins.clk;
  assign out_mosi_bit         = state_r.pins.mosi;
  assign out_nozzle_heater    = state_r.pins.noz;
  assign out_bed_heater       = state_r.pins.bed;
  assign out_readings_updated = updated_r;
  assign out_nozzle_counts    = state_r.nozzle_reading;
  assign out_bed_counts       = state_r.bed_reading;

endmodule

/* test/tb_spi_dual_adc_thermostat.sv */
// ----------------------------------------------------------------------------
// tb_spi_dual_adc_thermostat
// Self-checking bench for the dual-channel SPI ADC thermostat.
// ----------------------------------------------------------------------------
// Each input beat carries one MISO sample and yields one output beat. ADC
// words are fed as full 36-tick conversions, bed channel first. Many words sit
// next to the heater setpoints. A few bursts of loose samples are mixed in.
// Every output beat is checked against a tick-accurate model of the SPI
// sequencer and the heater compare. Both sides insert random gaps, except
// during one long stretch with no gaps at all.
// ----------------------------------------------------------------------------
module tb_spi_dual_adc_thermostat;
  import sdat_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FrameTicks = 36;
  localparam logic [WordW-1:0] WordMax = '1;

  typedef struct packed {
    logic             cs;
    logic             sclk;
    logic             mosi;
    logic             nozzle_on;
    logic             bed_on;
    logic             updated;
    logic [WordW-1:0] noz_counts;
    logic [WordW-1:0] bed_counts;
  } tick_result_t;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             cfg_wr_en   = 1'b0;
  logic             cfg_index   = 1'b0;
  logic [WordW-1:0] cfg_wdata   = '0;
  logic             in_valid    = 1'b0;
  logic             in_miso_bit = 1'b0;
  logic             out_stall   = 1'b0;
  logic             in_stall;
  logic             out_valid;
  logic             out_chip_select;
  logic             out_serial_clock;
  logic             out_mosi_bit;
  logic             out_nozzle_heater;
  logic             out_bed_heater;
  logic             out_readings_updated;
  logic [WordW-1:0] out_nozzle_counts;
  logic [WordW-1:0] out_bed_counts;

  logic idle_en = 1'b1;
  int   err_cnt = 0;

  tick_result_t pending_ticks[$];

  phase_t            adc_phase;
  logic [WordW-1:0]  adc_shift;
  logic [CountW-1:0] adc_bits;
  logic              adc_chan;
  logic [WordW-1:0]  noz_rd;
  logic [WordW-1:0]  bed_rd;
  logic              pin_cs;
  logic              pin_sclk;
  logic              pin_mosi;
  logic              heat_noz;
  logic              heat_bed;
  logic [WordW-1:0]  noz_thr;
  logic [WordW-1:0]  bed_thr;

  spi_dual_adc_thermostat u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_miso_bit          (in_miso_bit),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_chip_select      (out_chip_select),
    .out_serial_clock     (out_serial_clock),
    .out_mosi_bit         (out_mosi_bit),
    .out_nozzle_heater    (out_nozzle_heater),
    .out_bed_heater       (out_bed_heater),
    .out_readings_updated (out_readings_updated),
    .out_nozzle_counts    (out_nozzle_counts),
    .out_bed_counts       (out_bed_counts)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic tick_result_t step_adc(input logic miso);
    tick_result_t r;
    logic [15:0]  cmd;
    logic         upd;
    upd = 1'b0;
    case (adc_phase)
      PH_CLK_LOW: begin
        pin_sclk  = 1'b0;
        adc_phase = PH_CS_LOW;
      end
      PH_CS_LOW: begin
        pin_cs    = 1'b0;
        pin_mosi  = 1'b1;
        adc_phase = PH_BIT_CLK;
      end
      PH_BIT_CLK: begin
        pin_sclk  = 1'b1;
        adc_phase = PH_BIT_RW;
      end
      PH_BIT_RW: begin
        adc_shift = {adc_shift[WordW-2:0], miso};
        pin_sclk  = 1'b0;
        cmd       = adc_chan ? CMD_CH1 : CMD_CH0;
        pin_mosi  = (adc_bits <= TOP_BIT) ? cmd[4'(TOP_BIT - adc_bits)] : 1'b0;
        adc_bits  = adc_bits + CountW'(1);
        adc_phase = (adc_bits < NUM_BITS) ? PH_BIT_CLK : PH_LAST;
      end
      PH_LAST: begin
        adc_shift = {adc_shift[WordW-2:0], miso};
        pin_cs    = 1'b1;
        if (adc_chan) begin
          noz_rd = adc_shift;
        end else begin
          bed_rd = adc_shift;
        end
        upd       = adc_chan;
        adc_chan  = ~adc_chan;
        adc_phase = PH_CS_HIGH;
        if (upd) begin
          heat_noz = noz_rd < noz_thr;
          heat_bed = bed_rd < bed_thr;
        end
      end
      default: begin
        pin_cs    = 1'b1;
        adc_shift = '0;
        adc_bits  = '0;
        adc_phase = PH_CLK_LOW;
      end
    endcase
    r.cs         = pin_cs;
    r.sclk       = pin_sclk;
    r.mosi       = pin_mosi;
    r.nozzle_on  = heat_noz;
    r.bed_on     = heat_bed;
    r.updated    = upd;
    r.noz_counts = noz_rd;
    r.bed_counts = bed_rd;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [WordW-1:0] exp_val,
                                      input logic [WordW-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected 0x%05h, got 0x%05h", name, exp_val, act_val);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    tick_result_t exp_tick;
    if (!rst_n) begin
      adc_phase = PH_CS_HIGH;
      adc_shift = '0;
      adc_bits  = '0;
      adc_chan  = 1'b0;
      noz_rd    = '0;
      bed_rd    = '0;
      pin_cs    = 1'b0;
      pin_sclk  = 1'b0;
      pin_mosi  = 1'b0;
      heat_noz  = 1'b0;
      heat_bed  = 1'b0;
      noz_thr   = '0;
      bed_thr   = '0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_NOZZLE_THRESHOLD) begin
          noz_thr = cfg_wdata;
        end else if (cfg_index == CFG_BED_THRESHOLD) begin
          bed_thr = cfg_wdata;
        end
      end
      if (in_valid && !in_stall) begin
        pending_ticks.push_back(step_adc(in_miso_bit));
      end
      if (out_valid && !out_stall) begin
        if (pending_ticks.size() == 0) begin
          $error("output beat with no pending tick");
          err_cnt++;
        end else begin
          exp_tick = pending_ticks.pop_front();
          check_field("chip_select", WordW'(exp_tick.cs), WordW'(out_chip_select));
          check_field("serial_clock", WordW'(exp_tick.sclk), WordW'(out_serial_clock));
          check_field("mosi_bit", WordW'(exp_tick.mosi), WordW'(out_mosi_bit));
          check_field("nozzle_heater", WordW'(exp_tick.nozzle_on),
                      WordW'(out_nozzle_heater));
          check_field("bed_heater", WordW'(exp_tick.bed_on), WordW'(out_bed_heater));
          check_field("readings_updated", WordW'(exp_tick.updated),
                      WordW'(out_readings_updated));
          check_field("nozzle_counts", exp_tick.noz_counts, out_nozzle_counts);
          check_field("bed_counts", exp_tick.bed_counts, out_bed_counts);
        end
      end
    end
    out_stall <= idle_en && ($urandom_range(99) < 8);
  end

  task automatic send_tick(input logic miso);
    int gap;
    if (idle_en && $urandom_range(99) < 8) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_miso_bit <= miso;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_frame(input logic [WordW-1:0] word);
    repeat (3) send_tick(1'($urandom_range(1)));
    for (int i = WordW - 1; i >= 1; i--) begin
      send_tick(1'($urandom_range(1)));
      send_tick(word[i]);
    end
    send_tick(word[0]);
  endtask

  task automatic send_pair(input logic [WordW-1:0] noz_word, input logic [WordW-1:0] bed_word);
    send_frame(bed_word);
    send_frame(noz_word);
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 90);
    repeat (n) send_tick(1'($urandom_range(1)));
    repeat ((2 * FrameTicks - n % (2 * FrameTicks)) % (2 * FrameTicks)) begin
      send_tick(1'($urandom_range(1)));
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_ticks.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [WordW-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_thresholds(input logic [WordW-1:0] noz, input logic [WordW-1:0] bed);
    wait_idle();
    write_reg(CFG_NOZZLE_THRESHOLD, noz);
    write_reg(CFG_BED_THRESHOLD, bed);
  endtask

  function automatic logic [WordW-1:0] near_word(input logic [WordW-1:0] thr);
    case ($urandom_range(3))
      0:       return thr - WordW'(1);
      1:       return thr;
      2:       return thr + WordW'(1);
      default: return WordW'($urandom());
    endcase
  endfunction

  task automatic send_near_pair(input logic [WordW-1:0] noz, input logic [WordW-1:0] bed);
    send_pair(near_word(noz), near_word(bed));
  endtask

  task automatic test_reset_and_extremes();
    send_pair('0, WordMax);
    set_thresholds(WordMax, WordMax);
    send_pair('0, WordMax);
    send_pair(WordMax, '0);
  endtask

  task automatic test_threshold_sweep();
    logic [WordW-1:0] noz;
    logic [WordW-1:0] bed;
    for (int s = 0; s < 7; s++) begin
      case (s)
        0: begin noz = '0;      bed = '0;      end
        1: begin noz = WordMax; bed = WordMax; end
        2: begin noz = WordMax; bed = '0;      end
        3: begin noz = '0;      bed = WordMax; end
        4: begin noz = 17'd1;   bed = 17'd1;   end
        default: begin
          noz = WordW'($urandom());
          bed = WordW'($urandom());
        end
      endcase
      set_thresholds(noz, bed);
      send_near_pair(noz, bed);
    end
  endtask

  task automatic test_random_stream();
    logic [WordW-1:0] noz;
    logic [WordW-1:0] bed;
    noz = noz_thr;
    bed = bed_thr;
    idle_en <= 1'b0;
    for (int p = 0; p < 6; p++) begin
      if (p == 3) begin
        idle_en <= 1'b1;
      end
      if (p % 4 == 3) begin
        noz = WordW'($urandom());
        bed = WordW'($urandom());
        set_thresholds(noz, bed);
      end
      if (p == 2 || p == 4) begin
        send_noise();
      end
      if ($urandom_range(3) == 0) begin
        send_pair(WordW'($urandom()), WordW'($urandom()));
      end else begin
        send_near_pair(noz, bed);
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_and_extremes();
    test_threshold_sweep();
    test_random_stream();
    wait_idle();
    repeat (8) @(posedge clk);
    if (err_cnt == 0 && pending_ticks.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #400us;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
